FILE: src/id_number_checksum_date_validator_macros.svh
// Assertion macros for the identity number validator checker.
// Used by idcdv_checker; no other dependencies.
`ifndef ID_NUMBER_CHECKSUM_DATE_VALIDATOR_MACROS_SVH
`define ID_NUMBER_CHECKSUM_DATE_VALIDATOR_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define IDCDV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define IDCDV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/idcdv_pkg.sv
// Shared types, constants and small functions for the identity number validator.
// No dependencies.
`default_nettype none

package idcdv_pkg;

	localparam int unsigned POS_W = 5;

	localparam logic [POS_W-1:0] POS_CHECK = 5'd17;
	localparam logic [POS_W-1:0] POS_FULL  = 5'd18;
	localparam logic [POS_W-1:0] POS_OVER  = 5'd19;
	localparam logic [POS_W-1:0] POS_Y3    = 5'd6;
	localparam logic [POS_W-1:0] POS_Y2    = 5'd7;
	localparam logic [POS_W-1:0] POS_Y1    = 5'd8;
	localparam logic [POS_W-1:0] POS_Y0    = 5'd9;
	localparam logic [POS_W-1:0] POS_M1    = 5'd10;
	localparam logic [POS_W-1:0] POS_M0    = 5'd11;
	localparam logic [POS_W-1:0] POS_D1    = 5'd12;
	localparam logic [POS_W-1:0] POS_D0    = 5'd13;

	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_NINE = 8'd57;
	localparam logic [7:0] CHAR_X    = 8'd88;
	localparam logic [3:0] X_VALUE   = 4'd10;

	localparam logic [6:0] CENT_MIN  = 7'd15;
	localparam logic [6:0] YEAR_LOW  = 7'd82;
	localparam logic [6:0] MONTH_OCT = 7'd10;
	localparam logic [6:0] MONTH_FEB = 7'd2;
	localparam logic [6:0] MONTH_DEC = 7'd12;

	typedef struct packed {
		logic [3:0] y3;
		logic [3:0] y2;
		logic [3:0] y1;
		logic [3:0] y0;
		logic [3:0] m1;
		logic [3:0] m0;
		logic [3:0] d1;
		logic [3:0] d0;
	} date_digits_t;

	function automatic logic [3:0] weight_of(input logic [POS_W-1:0] pos);
		logic [3:0] w;
		case (pos)
			5'd0:    w = 4'd7;
			5'd1:    w = 4'd9;
			5'd2:    w = 4'd10;
			5'd3:    w = 4'd5;
			5'd4:    w = 4'd8;
			5'd5:    w = 4'd4;
			5'd6:    w = 4'd2;
			5'd7:    w = 4'd1;
			5'd8:    w = 4'd6;
			5'd9:    w = 4'd3;
			5'd10:   w = 4'd7;
			5'd11:   w = 4'd9;
			5'd12:   w = 4'd10;
			5'd13:   w = 4'd5;
			5'd14:   w = 4'd8;
			5'd15:   w = 4'd4;
			5'd16:   w = 4'd2;
			default: w = 4'd1;
		endcase
		return w;
	endfunction

	// Reduce a value below 128 modulo 11 by subtracting 88, 44, 22, 11.
	function automatic logic [3:0] mod11(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (r >= 7'd88) r = r - 7'd88;
		if (r >= 7'd44) r = r - 7'd44;
		if (r >= 7'd22) r = r - 7'd22;
		if (r >= 7'd11) r = r - 7'd11;
		return r[3:0];
	endfunction

	function automatic logic [4:0] month_days(input logic [6:0] m);
		logic [4:0] n;
		case (m)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
			7'd2:                                       n = 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
		return 7'(hi) * 7'd10 + 7'(lo);
	endfunction

endpackage

`default_nettype wire

FILE: src/idcdv_date_chk.sv
// Gregorian date check on captured decimal digits (October 1582 onward).
// Depends on idcdv_pkg.
`default_nettype none

module idcdv_date_chk
	import idcdv_pkg::*;
(
	input  date_digits_t digits,
	output logic         date_ok
);

	logic [6:0] cent;
	logic [6:0] yl;
	logic [6:0] month;
	logic [6:0] day;
	logic       year_ge;
	logic       year_eq;
	logic       leap;
	logic [4:0] lim;

	always_comb begin
		cent    = two_digits(digits.y3, digits.y2);
		yl      = two_digits(digits.y1, digits.y0);
		month   = two_digits(digits.m1, digits.m0);
		day     = two_digits(digits.d1, digits.d0);
		year_ge = (cent > CENT_MIN) || ((cent == CENT_MIN) && (yl >= YEAR_LOW));
		year_eq = (cent == CENT_MIN) && (yl == YEAR_LOW);
		leap    = (yl == 7'd0) ? (cent[1:0] == 2'd0) : (yl[1:0] == 2'd0);
		lim     = month_days(month);
		if ((month == MONTH_FEB) && leap) begin
			lim = 5'd29;
		end
		date_ok = year_ge && (month != 7'd0) && (month <= MONTH_DEC) && (day != 7'd0)
			&& !(year_eq && (month < MONTH_OCT)) && (day <= 7'(lim));
	end

endmodule

`default_nettype wire

FILE: src/id_number_checksum_date_validator.sv
// Identity number validator: ISO 7064 MOD 11-2 check character plus date check.
// Depends on idcdv_pkg and idcdv_date_chk.
//
// channel | dir | tdata (low bit up)      | tlast
// s_      | in  | [7:0] char_in           | is_last
// m_      | out | [0] valid_res, [7:1] 0  | -
//
// One character per cycle unless a last character waits on a stalled result: input
// register, then the state update and result into the output register.
// The s1 stage holds a last character while a result waits in the output register
// and m_tready is low.
// arst_n clears position, sum, digits and both valid flags.
`default_nettype none

module id_number_checksum_date_validator
	import idcdv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // is_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

	logic             s1_valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             out_valid_q;
	logic             out_res_q;
	logic [POS_W-1:0] pos_q;
	logic [3:0]       sum_q;
	logic             bad_q;
	date_digits_t     digits_q;

	logic             adv;
	logic             is_digit;
	logic [3:0]       digit;
	logic [POS_W-1:0] pos_n;
	logic [3:0]       sum_n;
	logic             bad_n;
	date_digits_t     digits_n;
	logic             date_ok;
	logic             res;

	idcdv_date_chk u_date (
		.digits  (digits_q),
		.date_ok (date_ok)
	);

	assign adv      = s1_valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !s1_valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_res_q};

	always_comb begin
		is_digit = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
		digit    = is_digit ? 4'(char_s1 - CHAR_ZERO) : 4'd0;
		sum_n    = sum_q;
		bad_n    = bad_q;
		digits_n = digits_q;
		if (pos_q < POS_CHECK) begin
			if (is_digit) begin
				sum_n = mod11(7'(sum_q) + 7'(digit) * 7'(weight_of(pos_q)));
				case (pos_q)
					POS_Y3:  digits_n.y3 = digit;
					POS_Y2:  digits_n.y2 = digit;
					POS_Y1:  digits_n.y1 = digit;
					POS_Y0:  digits_n.y0 = digit;
					POS_M1:  digits_n.m1 = digit;
					POS_M0:  digits_n.m0 = digit;
					POS_D1:  digits_n.d1 = digit;
					POS_D0:  digits_n.d0 = digit;
					default: digits_n = digits_q;
				endcase
			end else begin
				bad_n = 1'b1;
			end
		end else if (pos_q == POS_CHECK) begin
			if (is_digit) begin
				sum_n = mod11(7'(sum_q) + 7'(digit));
			end else if (char_s1 == CHAR_X) begin
				sum_n = mod11(7'(sum_q) + 7'(X_VALUE));
			end else begin
				bad_n = 1'b1;
			end
		end
		pos_n = (pos_q == POS_OVER) ? POS_OVER : pos_q + 5'd1;
		res   = (pos_n == POS_FULL) && !bad_n && (sum_n == 4'd1) && date_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			bad_q    <= 1'b0;
			digits_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q    <= '0;
				sum_q    <= '0;
				bad_q    <= 1'b0;
				digits_q <= '0;
			end else begin
				pos_q    <= pos_n;
				sum_q    <= sum_n;
				bad_q    <= bad_n;
				digits_q <= digits_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q   <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
			out_res_q   <= res;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: src/idcdv_checker.sv
// Port-level checker for the identity number validator, bound to the top level.
// Depends on id_number_checksum_date_validator_macros.svh.
`default_nettype none
`include "id_number_checksum_date_validator_macros.svh"

module idcdv_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire       s_tlast,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata
);

	logic [1:0] pending_q;
	logic       inc;
	logic       dec;

	assign inc = s_tvalid && s_tready && s_tlast;
	assign dec = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (inc && !dec) begin
			pending_q <= pending_q + 2'd1;
		end else if (dec && !inc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`IDCDV_ASSERT_IMPL(a_out_hold, clk, arst_n, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)), "result transaction dropped or changed while stalled")
	`IDCDV_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[7:1] == 7'd0, "result padding bits not zero")
	`IDCDV_ASSERT_IMPL(a_no_spurious, clk, arst_n, m_tvalid, pending_q != 2'd0, "result transaction without a pending last character")
	`IDCDV_ASSERT(a_pending_bound, clk, arst_n, pending_q != 2'd3, "more than two numbers in flight")

endmodule

bind id_number_checksum_date_validator idcdv_checker u_idcdv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
